// ===== sv/lsd_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the deframer.
`timescale 1ns / 1ps

package lsd_pkg;

	localparam int CHUNK_BYTES = 65536;
	localparam int ADDR_W      = $clog2(CHUNK_BYTES);
	localparam int LEN_W       = $clog2(CHUNK_BYTES + 1);
	localparam int SYNC_LEN    = 32;
	localparam int LEN_BYTES   = 4;

	// request codes
	localparam logic [1:0] REQ_BEGIN  = 2'd0;
	localparam logic [1:0] REQ_APPEND = 2'd1;
	localparam logic [1:0] REQ_FETCH  = 2'd2;

	// result status codes
	localparam logic [1:0] STS_FOUND = 2'd0;
	localparam logic [1:0] STS_OK    = 2'd1;
	localparam logic [1:0] STS_FAIL  = 2'd2;
	localparam logic [1:0] STS_OVF   = 2'd3;

	// chunk state codes
	localparam logic [1:0] CST_RUN  = 2'd0;
	localparam logic [1:0] CST_OK   = 2'd1;
	localparam logic [1:0] CST_FAIL = 2'd2;

	// read address select
	localparam logic [1:0] RSEL_LEN  = 2'd0;
	localparam logic [1:0] RSEL_SYN  = 2'd1;
	localparam logic [1:0] RSEL_SRCH = 2'd2;

	localparam logic [7:0] SYNC_WORD [SYNC_LEN] = '{
		8'h1F, 8'hF7, 8'hF7, 8'h7E, 8'hBE, 8'hA6, 8'h5E, 8'h9E,
		8'h37, 8'hA6, 8'hF6, 8'h2E, 8'hFE, 8'hAE, 8'h47, 8'hA7,
		8'hB7, 8'h6E, 8'hBF, 8'hAF, 8'h16, 8'h9E, 8'h9F, 8'h37,
		8'hF6, 8'h57, 8'hF7, 8'h66, 8'hA7, 8'h06, 8'hAF, 8'hF7
	};

	typedef struct packed {
		logic       clr_chunk;
		logic       wr_byte;
		logic       k_clr;
		logic       k_inc;
		logic       ld_dlen;
		logic       ld_base;
		logic       rp_frame;
		logic       rp_sync;
		logic       at_ld;
		logic       at_inc;
		logic [1:0] rsel;
		logic       emit;
		logic [1:0] emit_status;
		logic       set_cst;
		logic [1:0] cst_val;
	} lsd_cmd_t;

	typedef struct packed {
		logic       len_full;
		logic       rp_at_end;
		logic       rest_lt4;
		logic       rest_lt32;
		logic       need_fail;
		logic       k_is3;
		logic       k_is31;
		logic       byte_match;
		logic       at_last;
		logic [1:0] cst;
	} lsd_sts_t;

endpackage

// ===== sv/length_syncword_deframer.sv =====
// Top level of the length-prefixed frame deframer with sync word.
// Begin, append and fetches on an ended or exhausted chunk are handled in idle; busy stays low.
// A fetch reads the store one byte at a time, each read followed by a wait state; a frame
// at the cursor takes a rest check, the four length bytes, a length check and the 32 sync
// word bytes; a sync search compares 1 to 32 bytes per candidate, then a second attempt.
// Results show on done for one cycle after the transaction ends; the receiver cannot stall.
// arst_n clears the length, cursor and chunk state; store contents are undefined.
`timescale 1ns / 1ps

module length_syncword_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [7:0]  data_byte,
	output logic        done,
	output logic [1:0]  status,
	output logic [15:0] frame_offset,
	output logic [16:0] frame_length
);

	lsd_pkg::lsd_cmd_t cmd;
	lsd_pkg::lsd_sts_t sts;

	lsd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.sts      (sts),
		.cmd      (cmd),
		.busy     (busy)
	);

	lsd_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.data_byte    (data_byte),
		.sts          (sts),
		.done         (done),
		.status       (status),
		.frame_offset (frame_offset),
		.frame_length (frame_length)
	);

endmodule

// ===== sv/lsd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/lsd_datapath.sv =====
// Datapath: chunk store, length and cursor registers, frame checks and result register.
`timescale 1ns / 1ps

module lsd_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  lsd_pkg::lsd_cmd_t cmd,
	input  logic [7:0]        data_byte,
	output lsd_pkg::lsd_sts_t sts,
	output logic              done,
	output logic [1:0]        status,
	output logic [15:0]       frame_offset,
	output logic [16:0]       frame_length
);

	localparam int AW = lsd_pkg::ADDR_W;
	localparam int LW = lsd_pkg::LEN_W;

	logic [LW-1:0] len_q, rp_q, base_q, at_q;
	logic [1:0]    cst_q;
	logic [31:0]   dlen_q;
	logic [4:0]    k_q;
	logic [LW-1:0] rest, raddr_full;
	logic [7:0]    rdata;
	logic [33:0]   need, base_sum;
	logic [31:0]   off32;

	// chunk store
	lsd_ram #(.WIDTH(8), .DEPTH(lsd_pkg::CHUNK_BYTES)) u_store (
		.clk   (clk),
		.we    (cmd.wr_byte),
		.waddr (len_q[AW-1:0]),
		.wdata (data_byte),
		.raddr (raddr_full[AW-1:0]),
		.rdata (rdata)
	);

	// read address
	always_comb begin
		unique case (cmd.rsel)
			lsd_pkg::RSEL_LEN:  raddr_full = rp_q + LW'(k_q);
			lsd_pkg::RSEL_SYN:  raddr_full = base_q + LW'(k_q);
			default:            raddr_full = at_q + LW'(k_q);
		endcase
	end

	// checks
	assign rest     = len_q - rp_q;
	assign need     = 34'(dlen_q) + 34'(lsd_pkg::LEN_BYTES + lsd_pkg::SYNC_LEN);
	assign base_sum = 34'(rp_q) + 34'(dlen_q) + 34'(lsd_pkg::LEN_BYTES);
	assign off32    = 32'(rp_q) + 32'(lsd_pkg::LEN_BYTES);

	always_comb begin
		sts.len_full   = 32'(len_q) >= 32'(lsd_pkg::CHUNK_BYTES);
		sts.rp_at_end  = rp_q >= len_q;
		sts.rest_lt4   = 32'(rest) < 32'(lsd_pkg::LEN_BYTES);
		sts.rest_lt32  = 32'(rest) < 32'(lsd_pkg::SYNC_LEN);
		sts.need_fail  = 34'(rest) < need;
		sts.k_is3      = k_q == 5'd3;
		sts.k_is31     = k_q == 5'd31;
		sts.byte_match = rdata == lsd_pkg::SYNC_WORD[k_q];
		sts.at_last    = at_q == (len_q - LW'(lsd_pkg::SYNC_LEN));
		sts.cst        = cst_q;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			rp_q  <= '0;
			cst_q <= lsd_pkg::CST_RUN;
			done  <= 1'b0;
		end else begin
			done <= cmd.emit;
			if (cmd.clr_chunk) begin
				len_q <= '0;
				rp_q  <= '0;
				cst_q <= lsd_pkg::CST_RUN;
			end
			if (cmd.wr_byte) begin
				len_q <= len_q + 1'b1;
			end
			if (cmd.rp_frame) begin
				rp_q <= base_q + LW'(lsd_pkg::SYNC_LEN);
			end
			if (cmd.rp_sync) begin
				rp_q <= at_q + LW'(lsd_pkg::SYNC_LEN);
			end
			if (cmd.set_cst) begin
				cst_q <= cmd.cst_val;
			end
		end
	end

	// working registers and result payload
	always_ff @(posedge clk) begin
		if (cmd.k_clr) begin
			k_q <= '0;
		end else if (cmd.k_inc) begin
			k_q <= k_q + 1'b1;
		end
		if (cmd.ld_dlen) begin
			dlen_q[8*k_q[1:0] +: 8] <= rdata;
		end
		if (cmd.ld_base) begin
			base_q <= base_sum[LW-1:0];
		end
		if (cmd.at_ld) begin
			at_q <= rp_q;
		end else if (cmd.at_inc) begin
			at_q <= at_q + 1'b1;
		end
		if (cmd.emit) begin
			status <= cmd.emit_status;
			if (cmd.emit_status == lsd_pkg::STS_FOUND) begin
				frame_offset <= off32[15:0];
				frame_length <= dlen_q[16:0];
			end else begin
				frame_offset <= '0;
				frame_length <= '0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_rp_in_chunk: assert property (@(posedge clk) disable iff (!arst_n)
		rp_q <= len_q) else $error("cursor beyond chunk end");
	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_byte |-> !sts.len_full) else $error("store write past capacity");
	a_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != lsd_pkg::STS_FOUND) |-> (frame_offset == '0 && frame_length == '0))
		else $error("non-frame result with nonzero fields");
`endif

endmodule

// ===== sv/lsd_ctrl.sv =====
// Controller: sequences appends, frame attempts and the sync word search.
`timescale 1ns / 1ps

module lsd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        req_type,
	input  lsd_pkg::lsd_sts_t sts,
	output lsd_pkg::lsd_cmd_t cmd,
	output logic              busy
);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_TRY     = 4'd1;
	localparam logic [3:0] S_LEN_RD  = 4'd2;
	localparam logic [3:0] S_LEN_WT  = 4'd3;
	localparam logic [3:0] S_CHK     = 4'd4;
	localparam logic [3:0] S_SYN_RD  = 4'd5;
	localparam logic [3:0] S_SYN_WT  = 4'd6;
	localparam logic [3:0] S_SRCH_RD = 4'd7;
	localparam logic [3:0] S_SRCH_WT = 4'd8;

	logic [3:0] state_q, state_d;
	logic       second_q, second_d;
	logic       attempt_fail;

	assign busy = state_q != S_IDLE;

	// next state and commands
	always_comb begin
		cmd          = '0;
		state_d      = state_q;
		second_d     = second_q;
		attempt_fail = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (req_type)
						lsd_pkg::REQ_BEGIN: cmd.clr_chunk = 1'b1;
						lsd_pkg::REQ_APPEND: begin
							if (sts.len_full) begin
								cmd.emit        = 1'b1;
								cmd.emit_status = lsd_pkg::STS_OVF;
							end else begin
								cmd.wr_byte = 1'b1;
							end
						end
						lsd_pkg::REQ_FETCH: begin
							if (sts.cst == lsd_pkg::CST_OK) begin
								cmd.emit        = 1'b1;
								cmd.emit_status = lsd_pkg::STS_OK;
							end else if (sts.cst == lsd_pkg::CST_FAIL) begin
								cmd.emit        = 1'b1;
								cmd.emit_status = lsd_pkg::STS_FAIL;
							end else if (sts.rp_at_end) begin
								cmd.emit        = 1'b1;
								cmd.emit_status = lsd_pkg::STS_OK;
								cmd.set_cst     = 1'b1;
								cmd.cst_val     = lsd_pkg::CST_OK;
							end else begin
								second_d = 1'b0;
								state_d  = S_TRY;
							end
						end
						default: ;
					endcase
				end
			end
			S_TRY: begin
				if (sts.rest_lt4) begin
					attempt_fail = 1'b1;
				end else begin
					cmd.k_clr = 1'b1;
					state_d   = S_LEN_RD;
				end
			end
			S_LEN_RD: begin
				cmd.rsel = lsd_pkg::RSEL_LEN;
				state_d  = S_LEN_WT;
			end
			S_LEN_WT: begin
				cmd.ld_dlen = 1'b1;
				cmd.k_inc   = 1'b1;
				state_d     = sts.k_is3 ? S_CHK : S_LEN_RD;
			end
			S_CHK: begin
				if (sts.need_fail) begin
					attempt_fail = 1'b1;
				end else begin
					cmd.ld_base = 1'b1;
					cmd.k_clr   = 1'b1;
					state_d     = S_SYN_RD;
				end
			end
			S_SYN_RD: begin
				cmd.rsel = lsd_pkg::RSEL_SYN;
				state_d  = S_SYN_WT;
			end
			S_SYN_WT: begin
				if (!sts.byte_match) begin
					attempt_fail = 1'b1;
				end else if (sts.k_is31) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = lsd_pkg::STS_FOUND;
					cmd.rp_frame    = 1'b1;
					state_d         = S_IDLE;
				end else begin
					cmd.k_inc = 1'b1;
					state_d   = S_SYN_RD;
				end
			end
			S_SRCH_RD: begin
				cmd.rsel = lsd_pkg::RSEL_SRCH;
				state_d  = S_SRCH_WT;
			end
			S_SRCH_WT: begin
				cmd.rsel = lsd_pkg::RSEL_SRCH;
				if (sts.byte_match) begin
					if (sts.k_is31) begin
						cmd.rp_sync = 1'b1;
						second_d    = 1'b1;
						state_d     = S_TRY;
					end else begin
						cmd.k_inc = 1'b1;
						state_d   = S_SRCH_RD;
					end
				end else if (sts.at_last) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = lsd_pkg::STS_FAIL;
					cmd.set_cst     = 1'b1;
					cmd.cst_val     = lsd_pkg::CST_FAIL;
					state_d         = S_IDLE;
				end else begin
					cmd.at_inc = 1'b1;
					cmd.k_clr  = 1'b1;
					state_d    = S_SRCH_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase

		// a failed frame attempt: search once, else the chunk fails
		if (attempt_fail) begin
			if (second_q || sts.rest_lt32) begin
				cmd.emit        = 1'b1;
				cmd.emit_status = lsd_pkg::STS_FAIL;
				cmd.set_cst     = 1'b1;
				cmd.cst_val     = lsd_pkg::CST_FAIL;
				state_d         = S_IDLE;
			end else begin
				cmd.at_ld = 1'b1;
				cmd.k_clr = 1'b1;
				state_d   = S_SRCH_RD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			second_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			second_q <= second_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_emit_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> state_q == S_IDLE) else $error("result without return to idle");
	a_one_cmd_src: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.rp_frame && cmd.rp_sync)) else $error("two cursor updates at once");
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_byte || cmd.clr_chunk) |-> state_q == S_IDLE)
		else $error("chunk update during a fetch");
`endif

endmodule
